// ===== src/orbit_setpoint_pid_tracker_top_macros.svh =====
// ---------------------------------------------------------------------------
// Orbit set-point PID tracker: assertion macros
// Concurrent assertion wrappers on clk / arst_n; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ORBIT_SETPOINT_PID_TRACKER_TOP_MACROS_SVH
`define ORBIT_SETPOINT_PID_TRACKER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define OSP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define OSP_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`else
`define OSP_ASSERT(label, prop, msg)
`define OSP_ASSERT_IMPL(label, pre, post, msg)
`endif
`endif

// ===== src/osp_pkg.sv =====
// ---------------------------------------------------------------------------
// Orbit set-point PID tracker package
// Payload types, widths, sine polynomial constants, saturation helpers.
// ---------------------------------------------------------------------------
package osp_pkg;

	localparam int SINE_TABLE_BITS = 10;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int STEP_W     = 16;

	// shared multiplier: 49-bit signed by 18-bit signed, 67-bit product
	localparam int MUL_A_W = 49;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// divider numerator: difference of two 32-bit errors
	localparam int DIV_N_W = 33;

	// headroom width for sums ahead of saturation
	localparam int WIDE_W = 60;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_LOAD  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PROP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd4;

	localparam logic [15:0] ANG_QUARTER = 16'h4000;
	localparam logic [15:0] ANG_MASK =
		~((16'(1) << (16 - SINE_TABLE_BITS)) - 16'(1));
	localparam logic [14:0] SIN_U_FULL = 15'd16384;
	localparam logic [14:0] SIN_C0 = 15'd77;
	localparam logic [14:0] SIN_C1 = 15'd1306;
	localparam logic [14:0] SIN_C2 = 15'd10584;
	localparam logic [14:0] SIN_C3 = 15'd25736;
	localparam logic [15:0] SIN_MAX = 16'd32767;

	localparam logic signed [15:0] PROP_RESET = 16'sd256;

	typedef struct packed {
		logic [1:0]         op;
		logic [15:0]        step_time;
		logic               target_present;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] own_x;
		logic signed [31:0] own_y;
		logic signed [31:0] own_z;
		logic [15:0]        angle_load;
	} item_t;

	typedef struct packed {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [31:0] new_z;
		logic               moved;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ANG, ST_SQR, ST_H1, ST_H2, ST_H3, ST_SU, ST_OFF,
		ST_ERR, ST_EI, ST_DIV, ST_PF, ST_IF, ST_DF, ST_VF, ST_PV, ST_OUT
	} tick_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic ovf;
		ovf = (v[WIDE_W-1:31] != {(WIDE_W-31){v[WIDE_W-1]}});
		return ovf ? {v[WIDE_W-1], {31{~v[WIDE_W-1]}}} : v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [WIDE_W-1:0] v);
		logic ovf;
		ovf = (v[WIDE_W-1:47] != {(WIDE_W-47){v[WIDE_W-1]}});
		return ovf ? {v[WIDE_W-1], {47{~v[WIDE_W-1]}}} : v[47:0];
	endfunction

endpackage

// ===== src/osp_mul.sv =====
// ---------------------------------------------------------------------------
// Shared two-pass multiplier
// Signed 49x18 product built from two 25x18 partial products, low half first.
// ---------------------------------------------------------------------------
module osp_mul (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [osp_pkg::MUL_A_W-1:0]    a,
	input  logic signed [osp_pkg::MUL_B_W-1:0]    b,
	output logic                                  done,
	output logic signed [osp_pkg::MUL_P_W-1:0]    p
);
	import osp_pkg::*;

	localparam int HalfW = 24;
	localparam int PartW = MUL_A_W - HalfW + MUL_B_W;

	logic signed [MUL_A_W-1:0]       a_q;
	logic signed [MUL_B_W-1:0]       b_q;
	logic                            lo_pend_q;
	logic                            hi_pend_q;
	logic                            done_q;
	logic signed [MUL_A_W-HalfW-1:0] opa;
	logic signed [PartW-1:0]         part;
	logic signed [PartW-1:0]         lo_part_q;
	logic signed [MUL_P_W-1:0]       p_q;

	// low pass takes the unsigned low half, high pass the signed upper half
	assign opa  = lo_pend_q ? $signed({1'b0, a_q[HalfW-1:0]}) : a_q[MUL_A_W-1:HalfW];
	assign part = opa * b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_pend_q <= 1'b0;
			hi_pend_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			lo_pend_q <= start;
			hi_pend_q <= lo_pend_q;
			done_q    <= hi_pend_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (lo_pend_q) begin
			lo_part_q <= part;
		end
		if (hi_pend_q) begin
			p_q <= $signed({part, {HalfW{1'b0}}})
				+ $signed({{(MUL_P_W-PartW){lo_part_q[PartW-1]}}, lo_part_q});
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

// ===== src/osp_div.sv =====
// ---------------------------------------------------------------------------
// Serial derivative divider
// (num * 2^16) / den, truncated toward zero, saturated to 48 bits; one
// quotient bit per cycle.
// ---------------------------------------------------------------------------
module osp_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [osp_pkg::DIV_N_W-1:0]   num,
	input  logic [osp_pkg::STEP_W-1:0]           den,
	output logic                                 done,
	output logic signed [47:0]                   quot
);
	import osp_pkg::*;

	localparam int DivSteps = DIV_N_W + STEP_W;
	localparam int CntW     = $clog2(DivSteps + 1);

	logic                    busy_q;
	logic                    done_q;
	logic [CntW-1:0]         cnt_q;
	logic [DivSteps-1:0]     work_q;
	logic [STEP_W-1:0]       rem_q;
	logic [STEP_W-1:0]       den_q;
	logic                    neg_q;
	logic signed [47:0]      quot_q;
	logic [DIV_N_W-1:0]      num_abs;
	logic [STEP_W:0]         rem_sh;
	logic                    ge;
	logic [STEP_W-1:0]       rem_nx;
	logic [DivSteps-1:0]     work_nx;
	logic signed [WIDE_W-1:0] q_wide;

	assign num_abs = num[DIV_N_W-1] ? DIV_N_W'(-num) : DIV_N_W'(num);
	assign rem_sh  = {rem_q, work_q[DivSteps-1]};
	assign ge      = (rem_sh >= {1'b0, den_q});
	assign rem_nx  = ge ? STEP_W'(rem_sh - {1'b0, den_q}) : rem_sh[STEP_W-1:0];
	// dividend bits shift out the top while quotient bits shift in below
	assign work_nx = {work_q[DivSteps-2:0], ge};
	assign q_wide  = neg_q ? -$signed(WIDE_W'(work_nx)) : $signed(WIDE_W'(work_nx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DivSteps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= {num_abs, {STEP_W{1'b0}}};
			rem_q  <= '0;
			den_q  <= den;
			neg_q  <= num[DIV_N_W-1];
		end else if (busy_q) begin
			work_q <= work_nx;
			rem_q  <= rem_nx;
			if (cnt_q == CntW'(1)) begin
				quot_q <= sat48(q_wide);
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== src/orbit_setpoint_pid_tracker_top.sv =====
// ---------------------------------------------------------------------------
// Orbit set-point PID tracker
// Three-axis PID follower whose set-point circles a moving target.
// ---------------------------------------------------------------------------
// One item at a time. A tick with a target runs through one shared 49x18
// multiplier (31 products: angle advance, two polynomial sines with their
// radius scaling, six per axis) and a bit-serial divider for the derivative
// of each axis; the divide is skipped when step_time is zero. Clear, angle
// load, the unused op code and ticks without a target go straight to the
// output step. The result sits in an output register, so the next item is
// taken while a result waits to transfer. Config is written through cfg_we /
// cfg_index / cfg_data; the user must write it only while the block is idle,
// which the block itself does not enforce; an unknown index is ignored.
`include "orbit_setpoint_pid_tracker_top_macros.svh"

module orbit_setpoint_pid_tracker_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  osp_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output osp_pkg::result_t                  result,
	input  logic                              cfg_we,
	input  logic [osp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [osp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import osp_pkg::*;

	tick_state_t state_q, state_d;

	logic signed [15:0] prop_q, integ_q, deriv_q;
	logic signed [23:0] rate_q;
	logic [23:0]        radius_q;

	item_t              item_q;
	logic [15:0]        angle_q;
	logic signed [47:0] esum_q [3];
	logic signed [31:0] prev_q [3];
	logic signed [31:0] vel_q  [3];
	logic signed [31:0] newpos_q [3];
	logic               moved_q;
	result_t            result_q;
	logic               result_valid_q;

	logic               issued_q;
	logic [1:0]         axis_q;
	logic               sin_ph_q;
	logic [14:0]        u2_q;
	logic [14:0]        r_q;
	logic signed [15:0] sine_q;
	logic signed [25:0] offx_q, offy_q;
	logic signed [31:0] err_q;
	logic signed [47:0] der_q;
	logic signed [WIDE_W-1:0] facc_q;

	logic               accept, load_result, zero_step, last_axis;
	logic               mul_start, mul_done, div_start, div_done;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic signed [47:0] div_quot;
	logic signed [DIV_N_W-1:0] div_num;

	logic [15:0]        ang_tr;
	logic [1:0]         quad;
	logic [14:0]        u;
	logic [14:0]        p_q14;
	logic [15:0]        sine_mag;
	logic signed [31:0] tgt_sel, own_sel;
	logic signed [25:0] off_sel;
	logic signed [31:0] err_next;
	logic signed [WIDE_W-1:0] sh16, sh8;
	logic [MUL_B_W-1:0] step_b;

	assign accept      = item_valid && item_ready;
	assign item_ready  = (state_q == ST_IDLE);
	assign load_result = (state_q == ST_OUT) && (!result_valid_q || result_ready);
	assign zero_step   = (item_q.step_time == '0);
	assign last_axis   = (axis_q == 2'd2);
	assign step_b      = MUL_B_W'(item_q.step_time);

	// sine phase: cosine first, then sine; angle truncated to table resolution
	assign ang_tr = (angle_q + (sin_ph_q ? 16'd0 : ANG_QUARTER)) & ANG_MASK;
	assign quad   = ang_tr[15:14];
	assign u      = quad[0] ? (SIN_U_FULL - {1'b0, ang_tr[13:0]}) : {1'b0, ang_tr[13:0]};
	assign p_q14  = mul_p[28:14];
	assign sine_mag = ({p_q14, 1'b0} > SIN_MAX) ? SIN_MAX : {p_q14, 1'b0};

	assign sh16 = WIDE_W'($signed(mul_p[MUL_P_W-1:16]));
	assign sh8  = WIDE_W'($signed(mul_p[MUL_P_W-1:8]));

	always_comb begin
		case (axis_q)
			2'd0: begin
				tgt_sel = item_q.target_x;
				own_sel = item_q.own_x;
				off_sel = offx_q;
			end
			2'd1: begin
				tgt_sel = item_q.target_y;
				own_sel = item_q.own_y;
				off_sel = offy_q;
			end
			default: begin
				tgt_sel = item_q.target_z;
				own_sel = item_q.own_z;
				off_sel = '0;
			end
		endcase
	end

	assign err_next = sat32(WIDE_W'(tgt_sel) + WIDE_W'(off_sel) - WIDE_W'(own_sel));
	assign div_num  = DIV_N_W'(err_q) - DIV_N_W'(prev_q[axis_q]);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ANG: begin
				mul_a = MUL_A_W'(rate_q);
				mul_b = step_b;
			end
			ST_SQR: begin
				mul_a = {34'b0, u};
				mul_b = {3'b0, u};
			end
			ST_H1, ST_H2, ST_H3: begin
				mul_a = {34'b0, r_q};
				mul_b = {3'b0, u2_q};
			end
			ST_SU: begin
				mul_a = {34'b0, r_q};
				mul_b = {3'b0, u};
			end
			ST_OFF: begin
				mul_a = {25'b0, radius_q};
				mul_b = MUL_B_W'(sine_q);
			end
			ST_EI: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = step_b;
			end
			ST_PF: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = MUL_B_W'(prop_q);
			end
			ST_IF: begin
				mul_a = MUL_A_W'(esum_q[axis_q]);
				mul_b = MUL_B_W'(integ_q);
			end
			ST_DF: begin
				mul_a = MUL_A_W'(der_q);
				mul_b = MUL_B_W'(deriv_q);
			end
			ST_VF: begin
				mul_a = MUL_A_W'(sat48(facc_q));
				mul_b = step_b;
			end
			ST_PV: begin
				mul_a = MUL_A_W'(vel_q[axis_q]);
				mul_b = step_b;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	osp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	osp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (item_q.step_time),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.op == OP_TICK && item.target_present) begin
						state_d = ST_ANG;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_ANG, ST_SQR, ST_H1, ST_H2, ST_H3, ST_SU, ST_OFF,
			ST_EI, ST_PF, ST_IF, ST_DF, ST_VF, ST_PV: begin
				mul_start = !issued_q;
				if (mul_done) begin
					unique case (state_q)
						ST_ANG: state_d = ST_SQR;
						ST_SQR: state_d = ST_H1;
						ST_H1:  state_d = ST_H2;
						ST_H2:  state_d = ST_H3;
						ST_H3:  state_d = ST_SU;
						ST_SU:  state_d = ST_OFF;
						ST_OFF: state_d = sin_ph_q ? ST_ERR : ST_SQR;
						ST_EI:  state_d = ST_DIV;
						ST_PF:  state_d = ST_IF;
						ST_IF:  state_d = ST_DF;
						ST_DF:  state_d = ST_VF;
						ST_VF:  state_d = ST_PV;
						ST_PV:  state_d = last_axis ? ST_OUT : ST_ERR;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ERR: begin
				state_d = ST_EI;
			end
			ST_DIV: begin
				if (!issued_q && zero_step) begin
					state_d = ST_PF;
				end else begin
					div_start = !issued_q;
					if (div_done) begin
						state_d = ST_PF;
					end
				end
			end
			ST_OUT: begin
				if (load_result) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_q       <= 1'b0;
			result_valid_q <= 1'b0;
			prop_q         <= PROP_RESET;
			integ_q        <= '0;
			deriv_q        <= '0;
			rate_q         <= '0;
			radius_q       <= '0;
			angle_q        <= '0;
			for (int i = 0; i < 3; i++) begin
				esum_q[i] <= '0;
				prev_q[i] <= '0;
				vel_q[i]  <= '0;
			end
		end else begin
			if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end else if (mul_done || div_done) begin
				issued_q <= 1'b0;
			end

			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PROP:   prop_q   <= cfg_data[15:0];
					CFG_INTEG:  integ_q  <= cfg_data[15:0];
					CFG_DERIV:  deriv_q  <= cfg_data[15:0];
					CFG_RATE:   rate_q   <= cfg_data;
					CFG_RADIUS: radius_q <= cfg_data;
					default: ;
				endcase
			end

			if (accept && item.op == OP_CLEAR) begin
				for (int i = 0; i < 3; i++) begin
					esum_q[i] <= '0;
					prev_q[i] <= '0;
					vel_q[i]  <= '0;
				end
			end
			if (accept && item.op == OP_LOAD) begin
				angle_q <= item.angle_load;
			end

			if (mul_done) begin
				case (state_q)
					ST_ANG: angle_q <= angle_q + mul_p[31:16];
					ST_EI:  esum_q[axis_q] <= sat48(WIDE_W'(esum_q[axis_q]) + sh16);
					ST_VF:  vel_q[axis_q]  <= sat32(WIDE_W'(vel_q[axis_q]) + sh16);
					default: ;
				endcase
			end
			if (state_q == ST_DIV && ((!issued_q && zero_step) || div_done)) begin
				prev_q[axis_q] <= err_q;
			end
		end
	end

	// sequencer working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q      <= item;
			axis_q      <= '0;
			sin_ph_q    <= 1'b0;
			newpos_q[0] <= item.own_x;
			newpos_q[1] <= item.own_y;
			newpos_q[2] <= item.own_z;
			moved_q     <= (item.op == OP_TICK) && item.target_present;
		end
		if (state_q == ST_ERR) begin
			err_q <= err_next;
		end
		if (state_q == ST_DIV && ((!issued_q && zero_step) || div_done)) begin
			der_q <= zero_step ? '0 : div_quot;
		end
		if (mul_done) begin
			case (state_q)
				ST_SQR: begin
					u2_q <= p_q14;
					r_q  <= SIN_C0;
				end
				ST_H1: r_q <= SIN_C1 - p_q14;
				ST_H2: r_q <= SIN_C2 - p_q14;
				ST_H3: r_q <= SIN_C3 - p_q14;
				ST_SU: sine_q <= quad[1] ? -$signed(sine_mag) : $signed(sine_mag);
				ST_OFF: begin
					if (sin_ph_q) begin
						offy_q <= $signed(mul_p[40:15]);
					end else begin
						offx_q   <= $signed(mul_p[40:15]);
						sin_ph_q <= 1'b1;
					end
				end
				ST_PF: facc_q <= sh8;
				ST_IF, ST_DF: facc_q <= facc_q + sh8;
				ST_PV: begin
					newpos_q[axis_q] <= sat32(WIDE_W'(own_sel) + sh16);
					// advance to the next axis
					axis_q <= axis_q + 2'd1;
				end
				default: ;
			endcase
		end
		if (load_result) begin
			result_q.new_x <= newpos_q[0];
			result_q.new_y <= newpos_q[1];
			result_q.new_z <= newpos_q[2];
			result_q.moved <= moved_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`OSP_ASSERT_IMPL(a_mul_done_issued, mul_done, issued_q, "multiplier done without a start")
	`OSP_ASSERT_IMPL(a_div_done_state, div_done, (state_q == ST_DIV) && issued_q, "divider done outside divide step")
	`OSP_ASSERT_IMPL(a_axis_active, state_q == ST_ERR, axis_q != 2'd3, "axis counter past last axis")
	`OSP_ASSERT_IMPL(a_result_from_out, $rose(result_valid), $past(state_q == ST_OUT), "result raised outside output step")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Orbit set-point PID tracker testbench
// Drives operations through the item channel with random gaps and stalls,
// predicts every commanded position in fixed point and checks each result.
// ---------------------------------------------------------------------------
module tb_top;
	import osp_pkg::*;

	localparam int N_RANDOM = 600;

	// op code with no meaning, and a register index past the last register
	localparam logic [1:0]           OP_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BAD   = 3'd7;

	typedef struct {
		item_t   it;
		logic    has_exp;
		result_t exp;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	orbit_setpoint_pid_tracker_top dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#200000000;
		$display("orbit_setpoint_pid_tracker_top: mismatch");
		$finish;
	end

	// controller copy of the block
	logic signed [15:0] kp_m = PROP_RESET, ki_m = '0, kd_m = '0;
	logic signed [23:0] rate_m = '0;
	logic [23:0] radius_m = '0;
	logic [15:0] angle_m = '0;
	logic signed [47:0] integ_m [3];
	logic signed [31:0] prev_err_m [3];
	logic signed [31:0] vel_m [3];

	result_t pos_queue [$];
	int mismatches = 0;
	int n_sent = 0, n_got = 0, n_moved = 0;

	function automatic logic signed [127:0] clampw(logic signed [127:0] v, int bits);
		logic signed [127:0] hi, lo;
		hi = (128'sd1 <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic logic [63:0] qsine(logic [63:0] u);
		logic [63:0] u2, r;
		u2 = (u * u) >> 14;
		r = 77;
		r = 1306 - ((r * u2) >> 14);
		r = 10584 - ((r * u2) >> 14);
		r = 25736 - ((r * u2) >> 14);
		return (r * u) >> 14;
	endfunction

	function automatic logic signed [127:0] sine15(logic [15:0] ang);
		logic [15:0] a;
		logic [63:0] s;
		logic signed [127:0] v;
		a = ang & ANG_MASK;
		s = a[14] ? qsine(64'd16384 - a[13:0]) : qsine({50'd0, a[13:0]});
		v = $signed({64'd0, s}) * 2;
		if (v > 32767) v = 32767;
		return a[15] ? -v : v;
	endfunction

	function automatic result_t predict_position(item_t it);
		result_t r;
		logic signed [127:0] st, tgt[3], own[3], off[3], err, der, force_v, d;
		r.new_x = it.own_x; r.new_y = it.own_y; r.new_z = it.own_z; r.moved = 1'b0;
		if (it.op == OP_CLEAR) begin
			for (int i = 0; i < 3; i++) begin
				integ_m[i] = '0; prev_err_m[i] = '0; vel_m[i] = '0;
			end
			return r;
		end
		if (it.op == OP_LOAD) begin
			angle_m = it.angle_load;
			return r;
		end
		if (it.op != OP_TICK || !it.target_present) return r;
		st = $signed({112'd0, it.step_time});
		tgt[0] = 128'(it.target_x); tgt[1] = 128'(it.target_y); tgt[2] = 128'(it.target_z);
		own[0] = 128'(it.own_x); own[1] = 128'(it.own_y); own[2] = 128'(it.own_z);
		d = (128'(rate_m) * st) >>> 16;
		angle_m = angle_m + d[15:0];
		off[0] = (sine15(angle_m + ANG_QUARTER) * $signed({104'd0, radius_m})) >>> 15;
		off[1] = (sine15(angle_m) * $signed({104'd0, radius_m})) >>> 15;
		off[2] = '0;
		for (int i = 0; i < 3; i++) begin
			err = clampw(tgt[i] + off[i] - own[i], 32);
			integ_m[i] = 48'(clampw(128'(integ_m[i]) + ((err * st) >>> 16), 48));
			der = '0;
			if (st != 0) der = clampw(((err - 128'(prev_err_m[i])) * 65536) / st, 48);
			prev_err_m[i] = err[31:0];
			force_v = ((128'(kp_m) * err) >>> 8) + ((128'(ki_m) * 128'(integ_m[i])) >>> 8)
				+ ((128'(kd_m) * der) >>> 8);
			force_v = clampw(force_v, 48);
			vel_m[i] = 32'(clampw(128'(vel_m[i]) + ((force_v * st) >>> 16), 32));
			d = clampw(own[i] + ((128'(vel_m[i]) * st) >>> 16), 32);
			if (i == 0) r.new_x = d[31:0];
			else if (i == 1) r.new_y = d[31:0];
			else r.new_z = d[31:0];
		end
		r.moved = 1'b1;
		return r;
	endfunction

	// result side: random stalls, compare against oldest expectation
	int stall = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				n_got <= n_got + 1;
				if (result.moved) n_moved <= n_moved + 1;
				if (pos_queue.size() == 0) begin
					if (mismatches < 10) $display("unexpected result %h", result);
					mismatches++;
				end else begin
					result_t e;
					e = pos_queue.pop_front();
					if (e !== result) begin
						if (mismatches < 10)
							$display("result %0d: exp x=%h y=%h z=%h m=%b got x=%h y=%h z=%h m=%b",
								n_got, e.new_x, e.new_y, e.new_z, e.moved,
								result.new_x, result.new_y, result.new_z, result.moved);
						mismatches++;
					end
				end
				stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			end
			if (stall > 0) begin
				stall--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// hold valid until a transfer; ready is sampled ahead of each edge
	task automatic send_item(item_t it, logic has_exp, result_t exp_r, logic quiet);
		int gap;
		result_t p;
		logic rdy;
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		forever begin
			@(negedge clk);
			rdy = item_ready;
			@(posedge clk);
			if (rdy) break;
		end
		p = predict_position(it);
		if (has_exp && p !== exp_r) begin
			mismatches++;
			$display("table row disagrees with prediction");
		end
		pos_queue.push_back(p);
		n_sent++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pos_queue.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PROP:   kp_m = val[15:0];
			CFG_INTEG:  ki_m = val[15:0];
			CFG_DERIV:  kd_m = val[15:0];
			CFG_RATE:   rate_m = val;
			CFG_RADIUS: radius_m = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic item_t rand_item(logic wide);
		item_t it;
		it.op = ($urandom_range(0, 9) < 7) ? OP_TICK : 2'($urandom_range(1, 3));
		it.step_time = ($urandom_range(0, 7) == 0) ? 16'd0 :
			(wide ? 16'($urandom) : 16'($urandom_range(1, 4000)));
		it.target_present = ($urandom_range(0, 7) != 0);
		it.target_x = wide ? $urandom : $signed($urandom_range(0, 200000)) - 100000;
		it.target_y = wide ? $urandom : $signed($urandom_range(0, 200000)) - 100000;
		it.target_z = wide ? $urandom : $signed($urandom_range(0, 200000)) - 100000;
		it.own_x = wide ? $urandom : $signed($urandom_range(0, 200000)) - 100000;
		it.own_y = wide ? $urandom : $signed($urandom_range(0, 200000)) - 100000;
		it.own_z = wide ? $urandom : $signed($urandom_range(0, 200000)) - 100000;
		it.angle_load = 16'($urandom);
		return it;
	endfunction

	function automatic item_t mk(logic [1:0] op, logic [15:0] st, logic tp,
		logic signed [31:0] t, logic signed [31:0] o, logic [15:0] al);
		item_t it;
		it.op = op; it.step_time = st; it.target_present = tp;
		it.target_x = t; it.target_y = -t; it.target_z = t ^ 32'h5A5A;
		it.own_x = o; it.own_y = ~o; it.own_z = o + 7;
		it.angle_load = al;
		return it;
	endfunction

	vector_t stim_table [$];

	initial begin
		vector_t v;
		result_t e;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: Kp = 1, others zero; no target, clear, load and op 3 echo
		v.has_exp = 1'b1;
		v.it = mk(OP_TICK, 16'hFFFF, 1'b0, 32'sh7FFFFFFF, 32'sh80000000, 16'h0);
		e = '{v.it.own_x, v.it.own_y, v.it.own_z, 1'b0}; v.exp = e; stim_table.push_back(v);
		v.it = mk(OP_CLEAR, 16'h1234, 1'b1, 32'sd5, 32'sd9, 16'hFFFF);
		e = '{v.it.own_x, v.it.own_y, v.it.own_z, 1'b0}; v.exp = e; stim_table.push_back(v);
		v.it = mk(OP_UNUSED, 16'h1234, 1'b1, 32'sd5, 32'sd9, 16'hFFFF);
		e = '{v.it.own_x, v.it.own_y, v.it.own_z, 1'b0}; v.exp = e; stim_table.push_back(v);
		v.it = mk(OP_LOAD, 16'h0, 1'b0, 32'sd1, 32'sd2, 16'hFFFF);
		e = '{v.it.own_x, v.it.own_y, v.it.own_z, 1'b0}; v.exp = e; stim_table.push_back(v);
		// zero step: target present but nothing integrates, no divide
		v.it = mk(OP_TICK, 16'h0, 1'b1, 32'sd1000, 32'sd0, 16'h0);
		e = '{32'sd0, -32'sd1, 32'sd7, 1'b1}; v.exp = e; stim_table.push_back(v);
		v.it = mk(OP_LOAD, 16'h0, 1'b0, 32'sd1, 32'sd2, 16'h0);
		e = '{v.it.own_x, v.it.own_y, v.it.own_z, 1'b0}; v.exp = e; stim_table.push_back(v);
		v.has_exp = 1'b0;
		v.it = mk(OP_TICK, 16'hFFFF, 1'b1, 32'sh7FFFFFFF, 32'sh80000000, 16'h0);
		stim_table.push_back(v);
		v.it = mk(OP_TICK, 16'hFFFF, 1'b1, 32'sh80000000, 32'sh7FFFFFFF, 16'h0);
		stim_table.push_back(v);
		v.it = mk(OP_TICK, 16'h0001, 1'b1, 32'sd256, 32'sd0, 16'h0);
		stim_table.push_back(v);
		v.it = mk(OP_TICK, 16'h8000, 1'b1, -32'sd256, 32'sd100, 16'h0);
		stim_table.push_back(v);

		foreach (stim_table[i])
			send_item(stim_table[i].it, stim_table[i].has_exp, stim_table[i].exp, 1'b0);
		drain();

		// extreme settings, then several moderate ones
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_PROP, 24'h7FFF); write_reg(CFG_INTEG, 24'h7FFF);
					write_reg(CFG_DERIV, 24'h7FFF); write_reg(CFG_RATE, 24'h7FFFFF);
					write_reg(CFG_RADIUS, 24'hFFFFFF);
				end
				1: begin
					write_reg(CFG_PROP, 24'h8000); write_reg(CFG_INTEG, 24'h8000);
					write_reg(CFG_DERIV, 24'h8000); write_reg(CFG_RATE, 24'h800000);
					write_reg(CFG_RADIUS, 24'h0);
				end
				default: begin
					write_reg(CFG_PROP, 24'($urandom_range(0, 512)));
					write_reg(CFG_INTEG, 24'($urandom_range(0, 64)));
					write_reg(CFG_DERIV, 24'(16'($signed($urandom_range(0, 64)) - 32)));
					write_reg(CFG_RATE, 24'($urandom));
					write_reg(CFG_RADIUS, 24'($urandom_range(0, 65536)));
				end
			endcase
			write_reg(CFG_BAD, 24'hABCDEF);
			for (int k = 0; k < N_RANDOM / 6; k++) begin
				logic quiet;
				quiet = (k % 40) >= 30;
				if (k == 50) drain();
				send_item(rand_item(ph < 2 || $urandom_range(0, 4) == 0), 1'b0, '0, quiet);
			end
			drain();
		end

		$display("sent %0d items over six gain/orbit settings; %0d results, %0d moved",
			n_sent, n_got, n_moved);
		if (mismatches == 0) begin
			$display("orbit_setpoint_pid_tracker_top: match");
		end else begin
			$display("orbit_setpoint_pid_tracker_top: mismatch");
		end
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+src
src/osp_pkg.sv
src/osp_mul.sv
src/osp_div.sv
src/orbit_setpoint_pid_tracker_top.sv
sim/tb_top.sv
